>>> hw/rtl/fbmw_pkg.sv
`default_nettype none

package fbmw_pkg;

	localparam int unsigned IND_LOG2_MAX = 14;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_DIRECT       = 3'd1,
		PH_SINGLE_SLOT  = 3'd2,
		PH_DOUBLE_SLOT  = 3'd3,
		PH_DOUBLE_ENTRY = 3'd4,
		PH_SINGLE_ENTRY = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_READ_SLOT  = 3'd0,
		KIND_READ_ENTRY = 3'd1,
		KIND_MAPPED     = 3'd2,
		KIND_HOLE       = 3'd3,
		KIND_ILLEGAL    = 3'd4,
		KIND_TOO_FAR    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CFG_BLOCK_SIZE_LOG2 = 3'd0,
		CFG_ZONE_SCALE      = 3'd1,
		CFG_DIRECT_ZONES    = 3'd2,
		CFG_INDIRECT_LOG2   = 3'd3,
		CFG_FIRST_DATA_ZONE = 3'd4,
		CFG_ZONE_COUNT      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0]  block_size_log2;
		logic [2:0]  zone_scale;
		logic [4:0]  direct_zones;
		logic [3:0]  indirect_log2;
		logic [31:0] first_data_zone;
		logic [31:0] zone_count;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  block_in_zone;
		logic [27:0] remaining_excess;
	} walk_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] block_number;
		logic [13:0] entry_index;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/file_block_map_walker.sv
// File block map walker.
// Input channel (in_valid/in_stall) carries command, position and zone_value.
// A start transaction (command 0) begins a walk for a byte position; a reply
// transaction (command 1) returns the zone read for the last request.
// Output channel (out_valid/out_stall) carries kind, block_number and
// entry_index: a request for an inode slot or indirect entry, or a final
// mapped block, hole, illegal zone or too-far result.
// Config port: cfg_we writes cfg_data into register cfg_index; write only
// while no walk transaction is in flight.
// An accepted input is held in the input stage, resolved in one step against
// the walk state and the registers, and written into the output register.
// Throughput is one transaction per cycle unless out_stall holds, limited by
// the single input stage feeding the output register.
// A reply while no walk is pending produces no output and is consumed.
// Reset clears the walk state, restores the register defaults and empties
// both stages. When out_stall holds, the output register keeps its result,
// the input stage fills and in_stall rises; nothing is dropped.
`default_nettype none

module file_block_map_walker
	import fbmw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [31:0] position,
	input  wire logic [31:0] zone_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [31:0]      block_number,
	output logic [13:0]      entry_index
);

	cfg_t        cfg_q;
	walk_t       walk_q;
	walk_t       walk_nxt;
	logic        valid_s1;
	logic        command_s1;
	logic [31:0] position_s1;
	logic [31:0] zone_value_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res;
	logic        has_res;
	logic        out_free;
	logic        fire;
	logic        in_take;

	fbmw_step u_step (
		.cfg        (cfg_q),
		.cur        (walk_q),
		.command    (command_s1),
		.position   (position_s1),
		.zone_value (zone_value_s1),
		.nxt        (walk_nxt),
		.has_result (has_res),
		.result     (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && (out_free || !has_res);
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size_log2 <= 5'd10;
			cfg_q.zone_scale      <= 3'd0;
			cfg_q.direct_zones    <= 5'd7;
			cfg_q.indirect_log2   <= 4'd8;
			cfg_q.first_data_zone <= 32'd0;
			cfg_q.zone_count      <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_SIZE_LOG2: cfg_q.block_size_log2 <= cfg_data[4:0];
				CFG_ZONE_SCALE:      cfg_q.zone_scale      <= cfg_data[2:0];
				CFG_DIRECT_ZONES:    cfg_q.direct_zones    <= cfg_data[4:0];
				CFG_INDIRECT_LOG2:   cfg_q.indirect_log2   <= cfg_data[3:0];
				CFG_FIRST_DATA_ZONE: cfg_q.first_data_zone <= cfg_data;
				CFG_ZONE_COUNT:      cfg_q.zone_count      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.phase            <= PH_IDLE;
			walk_q.block_in_zone    <= '0;
			walk_q.remaining_excess <= '0;
		end else if (fire) begin
			walk_q <= walk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1    <= command;
			position_s1   <= position;
			zone_value_s1 <= zone_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign block_number = res_q.block_number;
	assign entry_index  = res_q.entry_index;

`ifndef SYNTHESIS
	a_final_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && has_res && (res.kind == KIND_MAPPED || res.kind == KIND_HOLE ||
		 res.kind == KIND_ILLEGAL || res.kind == KIND_TOO_FAR))
		|=> walk_q.phase == PH_IDLE)
		else $error("walk not idle after final result");

	a_entry_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && has_res && res.kind == KIND_READ_ENTRY)
		|=> (walk_q.phase == PH_SINGLE_ENTRY || walk_q.phase == PH_DOUBLE_ENTRY))
		else $error("entry request without entry phase");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_out_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && has_res))
		else $error("output valid without a resolved transaction");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/fbmw_step.sv
`default_nettype none

module fbmw_step
	import fbmw_pkg::*;
(
	input  cfg_t        cfg,
	input  walk_t       cur,
	input  logic        command,
	input  logic [31:0] position,
	input  logic [31:0] zone_value,
	output walk_t       nxt,
	output logic        has_result,
	output result_t     result
);

	logic [31:0] bpos;
	logic [31:0] zone;
	logic [7:0]  biz_mask;
	logic [6:0]  biz;
	logic [3:0]  il;
	logic [14:0] nind;
	logic [31:0] excess;
	logic [31:0] excess2;
	logic [4:0]  il2;
	logic        in_direct;
	logic        in_single;
	logic        too_far;
	logic [31:0] zbase;
	logic [31:0] mapped;
	logic        illegal;
	logic [27:0] rem_low;
	logic [27:0] rem_high;

	always_comb begin
		bpos      = position >> cfg.block_size_log2;
		zone      = bpos >> cfg.zone_scale;
		biz_mask  = (8'd1 << cfg.zone_scale) - 8'd1;
		biz       = bpos[6:0] & biz_mask[6:0];
		il        = (cfg.indirect_log2 > 4'(IND_LOG2_MAX)) ? 4'(IND_LOG2_MAX)
		                                                   : cfg.indirect_log2;
		nind      = 15'd1 << il;
		in_direct = zone < {27'd0, cfg.direct_zones};
		excess    = zone - {27'd0, cfg.direct_zones};
		in_single = excess < {17'd0, nind};
		excess2   = excess - {17'd0, nind};
		il2       = {il, 1'b0};
		// double-indirect reach is nind squared entries
		too_far   = (excess2 >> il2) != 32'd0;
		zbase     = zone_value << cfg.zone_scale;
		mapped    = zbase + {25'd0, cur.block_in_zone};
		illegal   = (zone_value != 32'd0) &&
		            ((zone_value < cfg.first_data_zone) || (zone_value >= cfg.zone_count));
		rem_low   = cur.remaining_excess & {13'd0, nind - 15'd1};
		rem_high  = cur.remaining_excess >> il;
	end

	always_comb begin
		nxt                 = cur;
		has_result          = 1'b1;
		result.kind         = KIND_HOLE;
		result.block_number = '0;
		result.entry_index  = '0;
		if (!command) begin
			nxt.block_in_zone = biz;
			if (in_direct) begin
				nxt.phase          = PH_DIRECT;
				result.kind        = KIND_READ_SLOT;
				result.entry_index = zone[13:0];
			end else if (in_single) begin
				nxt.phase            = PH_SINGLE_SLOT;
				nxt.remaining_excess = excess[27:0];
				result.kind          = KIND_READ_SLOT;
				result.entry_index   = {9'd0, cfg.direct_zones};
			end else if (too_far) begin
				nxt.phase   = PH_IDLE;
				result.kind = KIND_TOO_FAR;
			end else begin
				nxt.phase            = PH_DOUBLE_SLOT;
				nxt.remaining_excess = excess2[27:0];
				result.kind          = KIND_READ_SLOT;
				result.entry_index   = {9'd0, cfg.direct_zones} + 14'd1;
			end
		end else begin
			case (cur.phase)
				PH_DIRECT, PH_SINGLE_ENTRY: begin
					nxt.phase = PH_IDLE;
					if (cur.phase == PH_SINGLE_ENTRY && illegal) begin
						result.kind = KIND_ILLEGAL;
					end else if (zone_value == 32'd0) begin
						result.kind = KIND_HOLE;
					end else begin
						result.kind         = KIND_MAPPED;
						result.block_number = mapped;
					end
				end
				PH_SINGLE_SLOT, PH_DOUBLE_SLOT: begin
					if (zone_value == 32'd0) begin
						nxt.phase   = PH_IDLE;
						result.kind = KIND_HOLE;
					end else begin
						nxt.phase           = (cur.phase == PH_SINGLE_SLOT) ? PH_SINGLE_ENTRY
						                                                    : PH_DOUBLE_ENTRY;
						result.kind         = KIND_READ_ENTRY;
						result.block_number = zbase;
						result.entry_index  = (cur.phase == PH_SINGLE_SLOT)
						                      ? cur.remaining_excess[13:0] : rem_high[13:0];
					end
				end
				PH_DOUBLE_ENTRY: begin
					if (illegal) begin
						nxt.phase   = PH_IDLE;
						result.kind = KIND_ILLEGAL;
					end else if (zone_value == 32'd0) begin
						nxt.phase   = PH_IDLE;
						result.kind = KIND_HOLE;
					end else begin
						nxt.phase            = PH_SINGLE_ENTRY;
						nxt.remaining_excess = rem_low;
						result.kind          = KIND_READ_ENTRY;
						result.block_number  = zbase;
						result.entry_index   = rem_low[13:0];
					end
				end
				default: begin
					// reply with no walk in progress is dropped
					nxt.phase  = PH_IDLE;
					has_result = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/walk_tb_pkg.sv
package walk_tb_pkg;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_REPLY = 1'b1
	} cmd_t;

endpackage

>>> tb/sv/walk_checker.sv
module walk_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        command,
	input  wire logic [31:0] position,
	input  wire logic [31:0] zone_value,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] block_number,
	input  wire logic [13:0] entry_index,
	output int               outstanding,
	output int               fail_count
);
	import fbmw_pkg::*;
	import walk_tb_pkg::*;

	logic [4:0]  blk_log2;
	logic [2:0]  zone_scale;
	logic [4:0]  direct_slots;
	logic [3:0]  ind_log2;
	logic [31:0] first_zone;
	logic [31:0] zone_total;

	phase_t      phase;
	logic [6:0]  in_zone;
	logic [27:0] excess_left;

	result_t     awaited_results[$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch on %s: got %0h want %0h", $time, what, got, want);
	endtask

	// One step of the walk for an accepted transaction.
	task automatic advance_walk(input logic cmd, input logic [31:0] pos, input logic [31:0] zv,
			output bit produced, output result_t res);
		logic [63:0] nind;
		logic [63:0] bpos;
		logic [63:0] zone;
		logic [63:0] excess;
		logic [63:0] base;
		logic [63:0] shifted;
		int unsigned il;
		bit          bad;
		bit          leaf;
		produced = 1'b1;
		leaf = 1'b0;
		res.kind = KIND_READ_SLOT;
		res.block_number = 32'd0;
		res.entry_index = 14'd0;
		il = (ind_log2 > IND_LOG2_MAX) ? IND_LOG2_MAX : ind_log2;
		nind = 64'd1 << il;
		base = ({32'd0, zv} << zone_scale) & 64'hFFFF_FFFF;
		bad = (zv != 32'd0) && ((zv < first_zone) || (zv >= zone_total));
		if (cmd == CMD_START) begin
			bpos = {32'd0, pos} >> blk_log2;
			zone = bpos >> zone_scale;
			in_zone = bpos[6:0] & ((7'd1 << zone_scale) - 7'd1);
			if (zone < direct_slots) begin
				phase = PH_DIRECT;
				res.entry_index = zone[13:0];
			end else begin
				excess = zone - direct_slots;
				if (excess < nind) begin
					excess_left = excess[27:0];
					phase = PH_SINGLE_SLOT;
					res.entry_index = {9'd0, direct_slots};
				end else begin
					excess = excess - nind;
					if (excess >= nind * nind) begin
						phase = PH_IDLE;
						res.kind = KIND_TOO_FAR;
					end else begin
						excess_left = excess[27:0];
						phase = PH_DOUBLE_SLOT;
						res.entry_index = {9'd0, direct_slots} + 14'd1;
					end
				end
			end
		end else begin
			case (phase)
				PH_DIRECT: leaf = 1'b1;
				PH_SINGLE_SLOT, PH_DOUBLE_SLOT: begin
					if (zv == 32'd0) begin
						phase = PH_IDLE;
						res.kind = KIND_HOLE;
					end else begin
						shifted = (phase == PH_DOUBLE_SLOT) ? ({36'd0, excess_left} >> il)
							: {36'd0, excess_left};
						phase = (phase == PH_DOUBLE_SLOT) ? PH_DOUBLE_ENTRY : PH_SINGLE_ENTRY;
						res.kind = KIND_READ_ENTRY;
						res.block_number = base[31:0];
						res.entry_index = shifted[13:0];
					end
				end
				PH_DOUBLE_ENTRY: begin
					if (bad) begin
						phase = PH_IDLE;
						res.kind = KIND_ILLEGAL;
					end else if (zv == 32'd0) begin
						phase = PH_IDLE;
						res.kind = KIND_HOLE;
					end else begin
						shifted = {36'd0, excess_left} & (nind - 64'd1);
						excess_left = shifted[27:0];
						phase = PH_SINGLE_ENTRY;
						res.kind = KIND_READ_ENTRY;
						res.block_number = base[31:0];
						res.entry_index = shifted[13:0];
					end
				end
				PH_SINGLE_ENTRY: begin
					if (bad) begin
						phase = PH_IDLE;
						res.kind = KIND_ILLEGAL;
					end else begin
						leaf = 1'b1;
					end
				end
				default: begin
					// reply with no walk pending is swallowed
					phase = PH_IDLE;
					produced = 1'b0;
				end
			endcase
			if (leaf) begin
				phase = PH_IDLE;
				if (zv == 32'd0) begin
					res.kind = KIND_HOLE;
				end else begin
					res.kind = KIND_MAPPED;
					res.block_number = base[31:0] + {25'd0, in_zone};
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t next_res;
		bit      produced;
		if (!arst_n) begin
			blk_log2 = 5'd10;
			zone_scale = 3'd0;
			direct_slots = 5'd7;
			ind_log2 = 4'd8;
			first_zone = 32'd0;
			zone_total = 32'hFFFF_FFFF;
			phase = PH_IDLE;
			in_zone = 7'd0;
			excess_left = 28'd0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BLOCK_SIZE_LOG2: blk_log2 = cfg_data[4:0];
					CFG_ZONE_SCALE:      zone_scale = cfg_data[2:0];
					CFG_DIRECT_ZONES:    direct_slots = cfg_data[4:0];
					CFG_INDIRECT_LOG2:   ind_log2 = cfg_data[3:0];
					CFG_FIRST_DATA_ZONE: first_zone = cfg_data;
					CFG_ZONE_COUNT:      zone_total = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report("result with none outstanding, kind", {29'd0, kind}, 32'd0);
				end else begin
					want = awaited_results.pop_front();
					if (kind !== want.kind)
						report("kind", {29'd0, kind}, {29'd0, want.kind});
					if (block_number !== want.block_number)
						report("block_number", block_number, want.block_number);
					if (entry_index !== want.entry_index)
						report("entry_index", {18'd0, entry_index}, {18'd0, want.entry_index});
				end
			end
			if (in_valid && !in_stall) begin
				advance_walk(command, position, zone_value, produced, next_res);
				if (produced)
					awaited_results.push_back(next_res);
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
module tb;
	import fbmw_pkg::*;
	import walk_tb_pkg::*;

	localparam int ITEMS       = 1850;
	localparam int STALL_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        command = 1'b0;
	logic [31:0] position = 32'd0;
	logic [31:0] zone_value = 32'd0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire [2:0]   kind;
	wire [31:0]  block_number;
	wire [13:0]  entry_index;

	int          outstanding;
	int          fail_count;

	// stimulus-side copy of the registers, used to aim positions and zones
	logic [4:0]  sz_log2 = 5'd10;
	logic [2:0]  zscale = 3'd0;
	logic [4:0]  ndirect = 5'd7;
	logic [3:0]  ilog2 = 4'd8;
	logic [31:0] zone_lo = 32'd0;
	logic [31:0] zone_hi = 32'hFFFF_FFFF;

	kind_t       last_kind = KIND_READ_SLOT;
	int          items_done = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          stall_mode = 0;
	int          mode_left = 0;
	int          hold_left = 0;

	file_block_map_walker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.position     (position),
		.zone_value   (zone_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.block_number (block_number),
		.entry_index  (entry_index)
	);

	walk_checker u_walk_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.position     (position),
		.zone_value   (zone_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.block_number (block_number),
		.entry_index  (entry_index),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// newest accepted result, for answering the walk's requests
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			last_kind <= kind_t'(kind);
	end

	// receiver back-pressure: a randomly chosen mode among four
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold_left == 0) begin
					out_stall <= ~out_stall;
					hold_left <= $urandom_range(1, 30);
				end else begin
					hold_left <= hold_left - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(input cmd_t cmd, input logic [31:0] pos, input logic [31:0] zv,
			input bit counted);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		zone_value <= zv;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (counted)
			items_done++;
	endtask

	// called in the step of an accepted transaction; waits for every result
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] bsl, input logic [31:0] zs,
			input logic [31:0] dz, input logic [31:0] il,
			input logic [31:0] lo, input logic [31:0] hi);
		write_reg(CFG_BLOCK_SIZE_LOG2, bsl);
		write_reg(CFG_ZONE_SCALE, zs);
		write_reg(CFG_DIRECT_ZONES, dz);
		write_reg(CFG_INDIRECT_LOG2, il);
		write_reg(CFG_FIRST_DATA_ZONE, lo);
		write_reg(CFG_ZONE_COUNT, hi);
		cfg_we <= 1'b0;
		sz_log2 = bsl[4:0];
		zscale = zs[2:0];
		ndirect = dz[4:0];
		ilog2 = il[3:0];
		zone_lo = lo;
		zone_hi = hi;
	endtask

	task automatic random_config();
		logic [31:0] lo;
		logic [31:0] hi;
		if ($urandom_range(0, 9) < 6) begin
			// shallow blocks and small indirect blocks keep every level reachable
			case ($urandom_range(0, 4))
				0: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
				1: begin lo = $urandom_range(1, 4096); hi = lo + $urandom_range(1, 1 << 20); end
				2: begin lo = $urandom; hi = $urandom; end
				3: begin lo = 32'd0; hi = $urandom_range(1, 4096); end
				default: begin lo = $urandom_range(0, 64); hi = 32'd0; end
			endcase
			set_config($urandom_range(9, 10), $urandom_range(0, 2), $urandom_range(1, 16),
				$urandom_range(7, 8), lo, hi);
		end else begin
			// junk above each narrow register's width
			lo = $urandom_range(0, 4096);
			set_config($urandom, $urandom, $urandom, $urandom, lo,
				lo + $urandom_range(0, 1 << 16));
		end
	endtask

	function automatic logic [31:0] make_position();
		logic [63:0] nind;
		logic [63:0] lo;
		logic [63:0] span;
		logic [63:0] zone;
		logic [63:0] bpos;
		logic [63:0] p;
		int unsigned r;
		int unsigned il;
		il = (ilog2 > IND_LOG2_MAX) ? IND_LOG2_MAX : ilog2;
		nind = 64'd1 << il;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			lo = 64'd0;
			span = {59'd0, ndirect};
		end else if (r < 55) begin
			lo = {59'd0, ndirect};
			span = nind;
		end else if (r < 80) begin
			lo = ndirect + nind;
			span = nind * nind;
		end else if (r < 90) begin
			lo = ndirect + nind + nind * nind;
			span = 64'd1024;
		end else begin
			return $urandom;
		end
		if (span == 64'd0) begin
			lo = 64'd0;
			span = nind;
		end
		case ($urandom_range(0, 4))
			0: zone = lo;
			1: zone = lo + span - 64'd1;
			default: zone = lo + $urandom_range(0, span[31:0] - 32'd1);
		endcase
		bpos = (zone << zscale) | ({32'd0, $urandom} & ((64'd1 << zscale) - 64'd1));
		p = (bpos << sz_log2) | ({32'd0, $urandom} & ((64'd1 << sz_log2) - 64'd1));
		return p[31:0];
	endfunction

	function automatic logic [31:0] pick_zone();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'd0;
		if (r < 16 && zone_lo > 32'd1)
			return $urandom_range(1, zone_lo - 32'd1);
		if (r < 24 && zone_hi != 32'd0)
			return $urandom_range(zone_hi, 32'hFFFF_FFFF);
		if (r < 30)
			return $urandom;
		if (r < 33)
			return 32'hFFFF_FFFF;
		if (zone_hi > zone_lo && zone_hi > 32'd1)
			return $urandom_range((zone_lo == 32'd0) ? 32'd1 : zone_lo, zone_hi - 32'd1);
		return $urandom;
	endfunction

	// Start a walk and answer each request until it ends. With pick set the
	// zones are random and the walk is sometimes abandoned mid-way.
	task automatic run_walk(input logic [31:0] pos, input logic [31:0] z0,
			input logic [31:0] z1, input logic [31:0] z2, input bit pick);
		int step;
		bit walking;
		logic [31:0] zv;
		send_item(CMD_START, pos, $urandom, 1'b1);
		settle(0);
		walking = 1'b1;
		step = 0;
		while (walking) begin
			if ((last_kind == KIND_READ_SLOT || last_kind == KIND_READ_ENTRY) &&
					!(pick && $urandom_range(0, 39) == 0)) begin
				zv = pick ? pick_zone() : ((step == 0) ? z0 : (step == 1) ? z1 : z2);
				send_item(CMD_REPLY, $urandom, zv, 1'b1);
				settle(0);
				step++;
			end else begin
				walking = 1'b0;
			end
		end
	endtask

	task automatic noise_burst(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				send_item(CMD_START, make_position(), $urandom, 1'b1);
			else
				send_item(CMD_REPLY, $urandom, pick_zone(), 1'b1);
		end
	endtask

	initial begin : stimulus
		int phase_no;
		int phase_end;
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: 1 KiB blocks, 7 direct slots, 256 entries per indirect
		run_walk(32'd0, 32'd5, 32'd0, 32'd0, 1'b0);
		run_walk((32'd6 << 10) | 32'd1023, 32'd0, 32'd0, 32'd0, 1'b0);
		run_walk(32'd7 << 10, 32'd100, 32'd200, 32'd0, 1'b0);
		run_walk((32'd262 << 10) | 32'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
		run_walk(32'd263 << 10, 32'd0, 32'd0, 32'd0, 1'b0);
		run_walk((32'd65798 << 10) | 32'd1023, 32'd9, 32'd0, 32'd0, 1'b0);
		run_walk(32'd300 << 10, 32'd9, 32'hFFFF_FFFF, 32'd0, 1'b0);
		run_walk(32'd65799 << 10, 32'd0, 32'd0, 32'd0, 1'b0);
		run_walk(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0);
		// reply with nothing pending, then a start that abandons a walk
		send_item(CMD_REPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_item(CMD_START, 32'd7 << 10, 32'd0, 1'b1);
		settle(0);
		run_walk(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);

		settle(4);
		set_config(32'd9, 32'd7, 32'd2, 32'd7, 32'h100, 32'h20000);
		// top zone shifted past 32 bits, then a legality miss below the window
		run_walk((32'd255 << 9) | 32'd511, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
		run_walk(32'd256 << 9, 32'h50, 32'hFF, 32'd0, 1'b0);

		phase_no = 0;
		while (items_done < ITEMS) begin
			settle(4);
			case (phase_no)
				0: set_config(32'd9, 32'd0, 32'd1, 32'd7, 32'd0, 32'hFFFF_FFFF);
				1: set_config(32'd16, 32'd7, 32'd16, 32'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: set_config(32'd31, 32'd7, 32'd0, 32'd15, 32'd0, 32'd0);
				default: random_config();
			endcase
			phase_no++;
			phase_end = items_done + $urandom_range(150, 300);
			while (items_done < phase_end && items_done < ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					settle(4);
				else if (pick < 86)
					run_walk(make_position(), 32'd0, 32'd0, 32'd0, 1'b1);
				else
					noise_burst($urandom_range(1, 8));
			end
		end

		settle(20);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
